FILE: design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// shared constants, codes and types of the priority task scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TASK_SLOTS      = 16;
    localparam int LOWEST_PRIORITY = 31;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int PRIO_W = $clog2(LOWEST_PRIORITY + 1);

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [PRIO_W-1:0] prio_t;

    typedef enum logic [1:0] {
        TS_FREE,
        TS_READY,
        TS_RUNNING,
        TS_SUSPENDED
    } task_state_t;

    localparam logic [2:0] ACT_CREATE   = 3'd0;
    localparam logic [2:0] ACT_SUSPEND  = 3'd1;
    localparam logic [2:0] ACT_RESUME   = 3'd2;
    localparam logic [2:0] ACT_DELETE   = 3'd3;
    localparam logic [2:0] ACT_SCHEDULE = 3'd4;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_BAD_PRIO = 3'd2;
    localparam logic [2:0] STAT_NO_TASK  = 3'd3;
    localparam logic [2:0] STAT_NO_READY = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CREATE,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_DEL_SCAN,
        ST_DEL_FIN,
        ST_SCH_SCAN,
        ST_SCH_WIN,
        ST_SCH_CUR,
        ST_RESP
    } fsm_state_t;

    typedef struct packed {
        task_state_t state;
        prio_t       prio;
    } slot_entry_t;

    typedef struct packed {
        logic        rd_en;
        slot_idx_t   rd_addr;
        logic        wr_en;
        slot_idx_t   wr_addr;
        slot_entry_t wr_data;
        logic        live_set;
        logic        live_clr;
    } slot_cmd_t;

    typedef struct packed {
        logic      rd_en;
        slot_idx_t rd_addr;
        logic      wr_en;
        slot_idx_t wr_addr;
        slot_idx_t wr_data;
    } order_cmd_t;

endpackage

FILE: design/priority_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_core
// one transaction at a time: create writes a free slot and the order list;
// suspend and resume read, then write the slot; delete scans the order list,
// moving later entries down, then clears the live bit; schedule scans it with
// one order list read per cycle, reads each listed slot, then marks the winner
// running and a running current task ready. the next transaction is accepted
// in the cycle after a result is loaded, while it waits in the output register.
// reset clears the live bits and counters at once; no clearing pass is run
// ----------------------------------------------------------------------------
module priority_task_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [3:0]  task_handle,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  result_handle,
    output logic        switch_needed,
    output logic [4:0]  task_total
);

    pts_pkg::fsm_state_t  state_reg, state_next;

    pts_pkg::slot_cmd_t   slot_cmd;
    pts_pkg::slot_entry_t slot_rd;
    logic [pts_pkg::TASK_SLOTS-1:0] live;
    logic                 free_found;
    pts_pkg::slot_idx_t   free_slot;
    pts_pkg::order_cmd_t  order_cmd;
    pts_pkg::slot_idx_t   order_rd;

    // control state
    pts_pkg::count_t      count_reg, count_next;
    logic                 cur_valid_reg, cur_valid_next;
    pts_pkg::slot_idx_t   cur_handle_reg, cur_handle_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 p1_valid_reg, p1_valid_next;
    logic                 p2_valid_reg, p2_valid_next;
    logic                 found_reg, found_next;
    pts_pkg::count_t      idx_reg, idx_next;

    // payload
    logic [2:0]           action_reg, action_next;
    logic [3:0]           handle_reg, handle_next;
    logic [7:0]           prio_req_reg, prio_req_next;
    logic [2:0]           res_status_reg, res_status_next;
    logic [3:0]           res_handle_reg, res_handle_next;
    logic                 res_switch_reg, res_switch_next;
    pts_pkg::slot_idx_t   p1_idx_reg, p1_idx_next;
    pts_pkg::slot_idx_t   p2_handle_reg, p2_handle_next;
    pts_pkg::prio_t       best_reg, best_next;
    pts_pkg::slot_idx_t   win_reg, win_next;
    logic [2:0]           out_status_reg, out_status_next;
    logic [3:0]           out_handle_reg, out_handle_next;
    logic                 out_switch_reg, out_switch_next;
    logic [4:0]           out_total_reg, out_total_next;

    pts_pkg::slot_idx_t   h_idx;
    logic                 h_live;
    logic                 scan_issue;
    logic                 del_done;
    logic                 sch_done;
    logic                 out_load;

    pts_slot_table u_slot_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (slot_cmd),
        .rd_data    (slot_rd),
        .live       (live),
        .free_found (free_found),
        .free_slot  (free_slot)
    );

    pts_order_list u_order_list (
        .clk     (clk),
        .cmd     (order_cmd),
        .rd_data (order_rd)
    );

    assign h_idx      = pts_pkg::SLOT_W'(handle_reg);
    assign h_live     = (int'(handle_reg) < pts_pkg::TASK_SLOTS) && live[h_idx];
    assign scan_issue = idx_reg < count_reg;
    assign del_done   = !scan_issue && !p1_valid_reg;
    assign sch_done   = !scan_issue && !p1_valid_reg && !p2_valid_reg;
    assign out_load   = (state_reg == pts_pkg::ST_RESP) && (!out_valid_reg || !out_stall);
    assign in_stall   = (state_reg != pts_pkg::ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        pts_pkg::ACT_CREATE:   state_next = pts_pkg::ST_CREATE;
                        pts_pkg::ACT_SUSPEND,
                        pts_pkg::ACT_RESUME:   state_next = pts_pkg::ST_RMW_RD;
                        pts_pkg::ACT_DELETE:   state_next = pts_pkg::ST_DEL_SCAN;
                        pts_pkg::ACT_SCHEDULE: state_next = pts_pkg::ST_SCH_SCAN;
                        default:               state_next = pts_pkg::ST_RESP;
                    endcase
                end
            end
            pts_pkg::ST_CREATE:
            begin
                state_next = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_RMW_RD:
            begin
                state_next = h_live ? pts_pkg::ST_RMW_WR : pts_pkg::ST_RESP;
            end
            pts_pkg::ST_RMW_WR:
            begin
                state_next = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_DEL_SCAN:
            begin
                if (!h_live)
                begin
                    state_next = pts_pkg::ST_RESP;
                end
                else if (del_done)
                begin
                    state_next = pts_pkg::ST_DEL_FIN;
                end
            end
            pts_pkg::ST_DEL_FIN:
            begin
                state_next = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_SCH_SCAN:
            begin
                if (sch_done)
                begin
                    state_next = pts_pkg::ST_SCH_WIN;
                end
            end
            pts_pkg::ST_SCH_WIN:
            begin
                if (!found_reg || (cur_valid_reg && cur_handle_reg == win_reg))
                begin
                    state_next = pts_pkg::ST_RESP;
                end
                else
                begin
                    state_next = pts_pkg::ST_SCH_CUR;
                end
            end
            pts_pkg::ST_SCH_CUR:
            begin
                state_next = pts_pkg::ST_RESP;
            end
            pts_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory commands
    always_comb
    begin
        slot_cmd        = '0;
        order_cmd       = '0;
        count_next      = count_reg;
        cur_valid_next  = cur_valid_reg;
        cur_handle_next = cur_handle_reg;
        p1_valid_next   = p1_valid_reg;
        p2_valid_next   = p2_valid_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        action_next     = action_reg;
        handle_next     = handle_reg;
        prio_req_next   = prio_req_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_switch_next = res_switch_reg;
        p1_idx_next     = p1_idx_reg;
        p2_handle_next  = p2_handle_reg;
        best_next       = best_reg;
        win_next        = win_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_switch_next = out_switch_reg;
        out_total_next  = out_total_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next     = action;
                    handle_next     = task_handle;
                    prio_req_next   = priority_req;
                    res_status_next = pts_pkg::STAT_OK;
                    res_handle_next = '0;
                    res_switch_next = 1'b0;
                    idx_next        = '0;
                    p1_valid_next   = 1'b0;
                    p2_valid_next   = 1'b0;
                    found_next      = 1'b0;
                end
            end

            pts_pkg::ST_CREATE:
            begin
                if (count_reg == pts_pkg::CNT_W'(pts_pkg::TASK_SLOTS))
                begin
                    res_status_next = pts_pkg::STAT_FULL;
                end
                else if (prio_req_reg > 8'(pts_pkg::LOWEST_PRIORITY))
                begin
                    res_status_next = pts_pkg::STAT_BAD_PRIO;
                end
                else if (!free_found)
                begin
                    res_status_next = pts_pkg::STAT_FULL;
                end
                else
                begin
                    slot_cmd.wr_en         = 1'b1;
                    slot_cmd.wr_addr       = free_slot;
                    slot_cmd.wr_data.state = pts_pkg::TS_READY;
                    slot_cmd.wr_data.prio  = pts_pkg::PRIO_W'(prio_req_reg);
                    slot_cmd.live_set      = 1'b1;
                    order_cmd.wr_en        = 1'b1;
                    order_cmd.wr_addr      = count_reg[pts_pkg::SLOT_W-1:0];
                    order_cmd.wr_data      = free_slot;
                    count_next             = count_reg + 1'b1;
                    res_handle_next        = 4'(free_slot);
                end
            end

            pts_pkg::ST_RMW_RD:
            begin
                if (h_live)
                begin
                    slot_cmd.rd_en   = 1'b1;
                    slot_cmd.rd_addr = h_idx;
                end
                else
                begin
                    res_status_next = pts_pkg::STAT_NO_TASK;
                end
            end

            pts_pkg::ST_RMW_WR:
            begin
                slot_cmd.wr_addr      = h_idx;
                slot_cmd.wr_data.prio = slot_rd.prio;
                if (action_reg == pts_pkg::ACT_SUSPEND)
                begin
                    slot_cmd.wr_en         = 1'b1;
                    slot_cmd.wr_data.state = pts_pkg::TS_SUSPENDED;
                end
                else if (slot_rd.state == pts_pkg::TS_SUSPENDED)
                begin
                    slot_cmd.wr_en         = 1'b1;
                    slot_cmd.wr_data.state = pts_pkg::TS_READY;
                end
            end

            pts_pkg::ST_DEL_SCAN:
            begin
                if (!h_live)
                begin
                    res_status_next = pts_pkg::STAT_NO_TASK;
                end
                else
                begin
                    order_cmd.rd_en   = scan_issue;
                    order_cmd.rd_addr = idx_reg[pts_pkg::SLOT_W-1:0];
                    if (scan_issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    p1_valid_next = scan_issue;
                    p1_idx_next   = idx_reg[pts_pkg::SLOT_W-1:0];
                    // after the match every entry moves down by one
                    if (p1_valid_reg)
                    begin
                        if (found_reg)
                        begin
                            order_cmd.wr_en   = 1'b1;
                            order_cmd.wr_addr = p1_idx_reg - 1'b1;
                            order_cmd.wr_data = order_rd;
                        end
                        else if (order_rd == h_idx)
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
            end

            pts_pkg::ST_DEL_FIN:
            begin
                if (found_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
                slot_cmd.wr_addr  = h_idx;
                slot_cmd.live_clr = 1'b1;
                if (cur_valid_reg && cur_handle_reg == h_idx)
                begin
                    cur_valid_next = 1'b0;
                end
            end

            pts_pkg::ST_SCH_SCAN:
            begin
                // stage 0: order list read
                order_cmd.rd_en   = scan_issue;
                order_cmd.rd_addr = idx_reg[pts_pkg::SLOT_W-1:0];
                if (scan_issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                p1_valid_next = scan_issue;
                // stage 1: slot read of the listed handle
                slot_cmd.rd_en   = p1_valid_reg;
                slot_cmd.rd_addr = order_rd;
                p2_valid_next    = p1_valid_reg;
                p2_handle_next   = order_rd;
                // stage 2: strict compare keeps the earliest on ties
                if (p2_valid_reg && slot_rd.state == pts_pkg::TS_READY &&
                    (!found_reg || slot_rd.prio < best_reg))
                begin
                    found_next = 1'b1;
                    best_next  = slot_rd.prio;
                    win_next   = p2_handle_reg;
                end
            end

            pts_pkg::ST_SCH_WIN:
            begin
                if (!found_reg)
                begin
                    res_status_next = pts_pkg::STAT_NO_READY;
                end
                else
                begin
                    res_handle_next = 4'(win_reg);
                    if (!(cur_valid_reg && cur_handle_reg == win_reg))
                    begin
                        slot_cmd.wr_en         = 1'b1;
                        slot_cmd.wr_addr       = win_reg;
                        slot_cmd.wr_data.state = pts_pkg::TS_RUNNING;
                        slot_cmd.wr_data.prio  = best_reg;
                        slot_cmd.rd_en         = cur_valid_reg;
                        slot_cmd.rd_addr       = cur_handle_reg;
                    end
                end
            end

            pts_pkg::ST_SCH_CUR:
            begin
                // a running current task drops back to ready
                if (cur_valid_reg && slot_rd.state == pts_pkg::TS_RUNNING)
                begin
                    slot_cmd.wr_en         = 1'b1;
                    slot_cmd.wr_addr       = cur_handle_reg;
                    slot_cmd.wr_data.state = pts_pkg::TS_READY;
                    slot_cmd.wr_data.prio  = slot_rd.prio;
                end
                cur_handle_next = win_reg;
                cur_valid_next  = 1'b1;
                res_switch_next = 1'b1;
            end

            pts_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_switch_next = res_switch_reg;
                    out_total_next  = 5'(count_reg);
                end
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pts_pkg::ST_IDLE;
            count_reg      <= '0;
            cur_valid_reg  <= 1'b0;
            cur_handle_reg <= '0;
            out_valid_reg  <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cur_valid_reg  <= cur_valid_next;
            cur_handle_reg <= cur_handle_next;
            out_valid_reg  <= out_valid_next;
            p1_valid_reg   <= p1_valid_next;
            p2_valid_reg   <= p2_valid_next;
            found_reg      <= found_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        handle_reg     <= handle_next;
        prio_req_reg   <= prio_req_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_switch_reg <= res_switch_next;
        p1_idx_reg     <= p1_idx_next;
        p2_handle_reg  <= p2_handle_next;
        best_reg       <= best_next;
        win_reg        <= win_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_switch_reg <= out_switch_next;
        out_total_reg  <= out_total_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_handle = out_handle_reg;
    assign switch_needed = out_switch_reg;
    assign task_total    = out_total_reg;

endmodule

FILE: design/pts_slot_table.sv
// ----------------------------------------------------------------------------
// pts_slot_table
// per-handle task memory (state and priority) with live bits and free finder
// ----------------------------------------------------------------------------
module pts_slot_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pts_pkg::slot_cmd_t                 cmd,
    output pts_pkg::slot_entry_t               rd_data,
    output logic [pts_pkg::TASK_SLOTS-1:0]     live,
    output logic                               free_found,
    output pts_pkg::slot_idx_t                 free_slot
);

    pts_pkg::slot_entry_t               mem [pts_pkg::TASK_SLOTS];
    logic [pts_pkg::TASK_SLOTS-1:0]     live_reg;
    logic [pts_pkg::TASK_SLOTS-1:0]     live_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data <= mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (cmd.live_set)
        begin
            live_next[cmd.wr_addr] = 1'b1;
        end
        if (cmd.live_clr)
        begin
            live_next[cmd.wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    // lowest free handle
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = pts_pkg::TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = pts_pkg::SLOT_W'(i);
            end
        end
    end

    assign live = live_reg;

endmodule

FILE: design/pts_order_list.sv
// ----------------------------------------------------------------------------
// pts_order_list
// list of live handles in creation order, one read and one write per cycle
// ----------------------------------------------------------------------------
module pts_order_list (
    input  logic                  clk,
    input  pts_pkg::order_cmd_t   cmd,
    output pts_pkg::slot_idx_t    rd_data
);

    pts_pkg::slot_idx_t mem [pts_pkg::TASK_SLOTS];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data <= mem[cmd.rd_addr];
        end
    end

endmodule
